/* sv/ipf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_pkg
// shared types, codes and helpers of the ipv4 host and prefix filter
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam int HOST_SLOTS_DEF = 64;
    localparam int NET_SLOTS_DEF  = 32;
    localparam int ADDR_W         = 32;
    localparam int LEN_W          = 6;
    localparam int IDX_W          = 6;
    localparam int LOOKUP_LIMIT   = 33;
    localparam logic [LEN_W-1:0] HOST_LEN = LEN_W'(ADDR_W);

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_FIRST  = 2'd1,
        ACT_ALL    = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_DUP_IGN = 2'd1,
        ST_DUP_ERR = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_HOST = 2'd1,
        KIND_NET  = 2'd2,
        KIND_RSVD = 2'd3
    } t_kind;

    localparam logic [1:0] RV_POSITIVE = 2'd0;
    localparam logic [1:0] RV_NEITHER  = 2'd2;
    localparam logic [1:0] V_NOMATCH   = 2'd0;
    localparam logic [1:0] V_POSITIVE  = 2'd1;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_DUPERR = 1'b1;

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        logic [ADDR_W-1:0] m;
        if (len == '0) begin
            m = '0;
        end else if (len >= HOST_LEN) begin
            m = '1;
        end else begin
            m = {ADDR_W{1'b1}} << (HOST_LEN - len);
        end
        return m;
    endfunction

endpackage

/* sv/ipf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_cell
// one rule slot: holds an entry and passes it to its neighbor on a rotate
// ----------------------------------------------------------------------------
module ipf_cell #(
    parameter int W = 34
) (
    input  logic         i_clk,
    input  logic         i_shift,
    input  logic         i_load,
    input  logic [W-1:0] i_next,
    input  logic [W-1:0] i_wdata,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_shift) begin
            n_data = i_next;
        end else if (i_load) begin
            n_data = i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* sv/ipf_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_ring
// ring of rule cells; a rotate moves every entry one cell toward the head
// ----------------------------------------------------------------------------
module ipf_ring #(
    parameter int DEPTH = 64,
    parameter int W     = 34,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_shift,
    input  logic          i_we,
    input  logic [IW-1:0] i_widx,
    input  logic [W-1:0]  i_wdata,
    output logic [W-1:0]  o_head
);

    logic [W-1:0] w_data [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        ipf_cell #(.W(W)) u_cell (
            .i_clk  (i_clk),
            .i_shift(i_shift),
            .i_load (i_we && (i_widx == IW'(k))),
            .i_next (w_data[(k + 1) % DEPTH]),
            .i_wdata(i_wdata),
            .o_data (w_data[k])
        );
    end

    assign o_head = w_data[0];

endmodule

/* sv/ipv4_host_and_prefix_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_host_and_prefix_filter
// ipv4 access list with host and prefix rules, first-match and all-positive
// lookup
// ----------------------------------------------------------------------------
// usage: items arrive on the slave stream (action, address, prefix_len,
// rule_verdict). insert adds a rule, lookup-first returns one result, lookup-all
// returns every positive match (at most 33) with tlast on the final one.
// rules sit in two rings of cells (hosts, networks). for each item both rings
// rotate once past a shared compare stage, one entry per cycle unless the scan
// is frozen (below). a new item is taken once the previous scan is done, while
// its last result may still wait in the output register.
// a stalled master side freezes the scan (rings stop rotating) while a
// lookup-all match waits for the output register; nothing is dropped.
// reset clears the rule counts and the control state; filter_enable resets to
// 0 and dup_is_error to 1. rule contents are not cleared; only entries below
// the counts are ever compared. config writes go in through i_cfg_we; the user
// must keep them to idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module ipv4_host_and_prefix_filter #(
    parameter int HOST_SLOTS = ipf_pkg::HOST_SLOTS_DEF,
    parameter int NET_SLOTS  = ipf_pkg::NET_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic        i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // action, address, prefix_len, rule_verdict
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // verdict, insert_status, match_kind,
                                     // match_index, match_prefix, match_net
    output logic        o_m_tlast
);

    localparam int AW   = ipf_pkg::ADDR_W;
    localparam int LW   = ipf_pkg::LEN_W;
    localparam int XW   = ipf_pkg::IDX_W;
    localparam int HIW  = (HOST_SLOTS > 1) ? $clog2(HOST_SLOTS) : 1;
    localparam int NIW  = (NET_SLOTS > 1) ? $clog2(NET_SLOTS) : 1;
    localparam int HCW  = $clog2(HOST_SLOTS + 1);
    localparam int NCW  = $clog2(NET_SLOTS + 1);
    localparam int SW   = $clog2(HOST_SLOTS + NET_SLOTS + 1);
    localparam int HW   = AW + 2;
    localparam int NW   = AW + LW + 2;
    localparam int CNTW = $clog2(ipf_pkg::LOOKUP_LIMIT + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state            r_state;
    logic [SW-1:0]     r_s;
    logic [HCW-1:0]    r_hcnt;
    logic [NCW-1:0]    r_ncnt;
    logic              r_en, r_dup;
    ipf_pkg::t_action  r_act;
    logic [AW-1:0]     r_addr, r_masked;
    logic [LW-1:0]     r_len;
    logic [1:0]        r_rv;
    logic              r_is_host, r_found, r_wr;
    logic [CNTW-1:0]   r_n;
    logic [1:0]        r_res_v;
    ipf_pkg::t_status  r_res_st;
    ipf_pkg::t_kind    r_res_k;
    logic [XW-1:0]     r_res_idx;
    logic [LW-1:0]     r_res_pfx;
    logic [AW-1:0]     r_res_net;
    logic              r_ov, r_olast;
    logic [1:0]        r_o_v;
    ipf_pkg::t_status  r_o_st;
    ipf_pkg::t_kind    r_o_k;
    logic [XW-1:0]     r_o_idx;
    logic [LW-1:0]     r_o_pfx;
    logic [AW-1:0]     r_o_net;

    // input decode
    ipf_pkg::t_action  w_act;
    logic [AW-1:0]     w_addr;
    logic [LW-1:0]     w_len_raw, w_len;
    logic [1:0]        w_rv_raw;

    assign w_act     = ipf_pkg::t_action'(i_s_tdata[1:0]);
    assign w_addr    = i_s_tdata[33:2];
    assign w_len_raw = i_s_tdata[39:34];
    assign w_rv_raw  = i_s_tdata[41:40];
    assign w_len     = (w_len_raw > ipf_pkg::HOST_LEN) ? ipf_pkg::HOST_LEN : w_len_raw;

    // rings
    logic [HW-1:0] w_hhead;
    logic [NW-1:0] w_nhead;
    logic          w_phase_host, w_adv, w_out_free, w_fin_go, w_hwe, w_nwe;

    ipf_ring #(.DEPTH(HOST_SLOTS), .W(HW), .IW(HIW)) u_host (
        .i_clk  (i_clk),
        .i_shift(w_adv && w_phase_host),
        .i_we   (w_hwe),
        .i_widx (r_hcnt[HIW-1:0]),
        .i_wdata({r_addr, r_rv}),
        .o_head (w_hhead)
    );

    ipf_ring #(.DEPTH(NET_SLOTS), .W(NW), .IW(NIW)) u_net (
        .i_clk  (i_clk),
        .i_shift(w_adv && !w_phase_host),
        .i_we   (w_nwe),
        .i_widx (r_ncnt[NIW-1:0]),
        .i_wdata({r_masked, r_len, r_rv}),
        .o_head (w_nhead)
    );

    // compare stage at the ring heads
    logic [AW-1:0]    w_ha, w_na;
    logic [1:0]       w_hv, w_nv;
    logic [LW-1:0]    w_np;
    logic [SW-1:0]    w_nidx;
    logic             w_hvalid, w_nvalid, w_hit, w_take, w_push, w_last_step;
    logic             w_load_o;
    logic [1:0]       w_it_v;
    ipf_pkg::t_kind   w_it_k;
    logic [XW-1:0]    w_it_idx;
    logic [LW-1:0]    w_it_pfx;
    logic [AW-1:0]    w_it_net;
    ipf_pkg::t_status w_dup_st;

    assign {w_ha, w_hv}       = w_hhead;
    assign {w_na, w_np, w_nv} = w_nhead;
    assign w_phase_host = r_s < SW'(HOST_SLOTS);
    assign w_nidx       = r_s - SW'(HOST_SLOTS);
    assign w_hvalid     = r_s < SW'(r_hcnt);
    assign w_nvalid     = w_nidx < SW'(r_ncnt);
    assign w_dup_st     = r_dup ? ipf_pkg::ST_DUP_ERR : ipf_pkg::ST_DUP_IGN;

    always_comb begin
        w_hit    = 1'b0;
        w_it_v   = ipf_pkg::V_NOMATCH;
        w_it_k   = ipf_pkg::KIND_HOST;
        w_it_idx = XW'(r_s);
        w_it_pfx = ipf_pkg::HOST_LEN;
        w_it_net = w_ha;
        if (w_phase_host) begin
            unique case (r_act)
                ipf_pkg::ACT_INSERT: w_hit = r_is_host && w_hvalid && (w_ha == r_addr);
                ipf_pkg::ACT_FIRST:  w_hit = r_en && w_hvalid && (w_ha == r_addr);
                ipf_pkg::ACT_ALL:    w_hit = r_en && w_hvalid && (w_ha == r_addr)
                                             && (w_hv == ipf_pkg::RV_POSITIVE);
                default:             w_hit = 1'b0;
            endcase
            if (r_act != ipf_pkg::ACT_INSERT) begin
                w_it_v = 2'(w_hv + 2'd1);
            end
        end else begin
            w_it_k   = ipf_pkg::KIND_NET;
            w_it_idx = XW'(w_nidx);
            w_it_pfx = w_np;
            w_it_net = w_na;
            unique case (r_act)
                ipf_pkg::ACT_INSERT: w_hit = !r_is_host && w_nvalid
                                             && (w_na == r_masked) && (w_np == r_len);
                ipf_pkg::ACT_FIRST:  w_hit = r_en && w_nvalid
                                             && ((r_addr & ipf_pkg::prefix_mask(w_np)) == w_na);
                ipf_pkg::ACT_ALL:    w_hit = r_en && w_nvalid
                                             && (w_nv == ipf_pkg::RV_POSITIVE)
                                             && ((r_addr & ipf_pkg::prefix_mask(w_np)) == w_na);
                default:             w_hit = 1'b0;
            endcase
            if (r_act != ipf_pkg::ACT_INSERT) begin
                w_it_v = 2'(w_nv + 2'd1);
            end
        end
    end

    assign w_take      = w_hit && !r_found;
    assign w_out_free  = !r_ov || i_m_tready;
    assign w_push      = w_take && (r_act == ipf_pkg::ACT_ALL) && (r_n != '0);
    assign w_adv       = (r_state == S_SCAN) && (!w_push || w_out_free);
    assign w_last_step = r_s == SW'(HOST_SLOTS + NET_SLOTS - 1);
    assign w_fin_go    = (r_state == S_FIN) && w_out_free;
    assign w_hwe       = w_fin_go && r_wr && r_is_host;
    assign w_nwe       = w_fin_go && r_wr && !r_is_host;
    assign w_load_o    = (w_adv && w_push) || w_fin_go;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hcnt  <= '0;
            r_ncnt  <= '0;
            r_en    <= 1'b0;
            r_dup   <= 1'b1;
            r_ov    <= 1'b0;
            r_s     <= '0;
            r_found <= 1'b0;
            r_wr    <= 1'b0;
            r_n     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ipf_pkg::CFG_ENABLE: r_en  <= i_cfg_data;
                    ipf_pkg::CFG_DUPERR: r_dup <= i_cfg_data;
                    default:             r_en  <= r_en;
                endcase
            end
            // output register fills on a push or a finish, empties on a transfer
            if (w_load_o) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && (w_act != ipf_pkg::ACT_NONE)) begin
                        r_state <= S_SCAN;
                        r_s     <= '0;
                        r_found <= 1'b0;
                        r_wr    <= 1'b0;
                        r_n     <= '0;
                    end
                end
                S_SCAN: begin
                    if (w_adv) begin
                        if (w_take) begin
                            if (r_act == ipf_pkg::ACT_ALL) begin
                                r_n <= CNTW'(r_n + 1'b1);
                                if (r_n == CNTW'(ipf_pkg::LOOKUP_LIMIT - 1)) begin
                                    r_found <= 1'b1;
                                end
                            end else begin
                                r_found <= 1'b1;
                            end
                        end
                        if (w_last_step) begin
                            r_s     <= '0;
                            r_state <= S_FIN;
                            if (r_act == ipf_pkg::ACT_INSERT && !r_found && !w_hit) begin
                                r_wr <= r_is_host ? (r_hcnt != HCW'(HOST_SLOTS))
                                                  : (r_ncnt != NCW'(NET_SLOTS));
                            end
                        end else begin
                            r_s <= SW'(r_s + 1'b1);
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                        if (w_hwe) begin
                            r_hcnt <= HCW'(r_hcnt + 1'b1);
                        end
                        if (w_nwe) begin
                            r_ncnt <= NCW'(r_ncnt + 1'b1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_act     <= w_act;
            r_addr    <= w_addr;
            r_masked  <= w_addr & ipf_pkg::prefix_mask(w_len);
            r_len     <= w_len;
            r_is_host <= w_len == ipf_pkg::HOST_LEN;
            r_rv      <= (w_rv_raw > ipf_pkg::RV_NEITHER) ? ipf_pkg::RV_NEITHER : w_rv_raw;
            r_res_v   <= ipf_pkg::V_NOMATCH;
            r_res_st  <= ipf_pkg::ST_ADDED;
            r_res_k   <= ipf_pkg::KIND_NONE;
            r_res_idx <= '0;
            r_res_pfx <= '0;
            r_res_net <= '0;
        end
        if (w_adv) begin
            if (w_push) begin
                r_o_v   <= r_res_v;
                r_o_st  <= r_res_st;
                r_o_k   <= r_res_k;
                r_o_idx <= r_res_idx;
                r_o_pfx <= r_res_pfx;
                r_o_net <= r_res_net;
                r_olast <= 1'b0;
            end
            if (w_take) begin
                r_res_v   <= w_it_v;
                r_res_st  <= (r_act == ipf_pkg::ACT_INSERT) ? w_dup_st : ipf_pkg::ST_ADDED;
                r_res_k   <= w_it_k;
                r_res_idx <= w_it_idx;
                r_res_pfx <= w_it_pfx;
                r_res_net <= w_it_net;
            end
            if (w_last_step && r_act == ipf_pkg::ACT_INSERT && !r_found && !w_hit) begin
                r_res_v <= ipf_pkg::V_NOMATCH;
                if (r_is_host ? (r_hcnt == HCW'(HOST_SLOTS)) : (r_ncnt == NCW'(NET_SLOTS))) begin
                    r_res_st  <= ipf_pkg::ST_FULL;
                    r_res_k   <= ipf_pkg::KIND_NONE;
                    r_res_idx <= '0;
                    r_res_pfx <= '0;
                    r_res_net <= '0;
                end else begin
                    r_res_st  <= ipf_pkg::ST_ADDED;
                    r_res_k   <= r_is_host ? ipf_pkg::KIND_HOST : ipf_pkg::KIND_NET;
                    r_res_idx <= r_is_host ? XW'(r_hcnt) : XW'(r_ncnt);
                    r_res_pfx <= r_len;
                    r_res_net <= r_masked;
                end
            end
        end
        if (w_fin_go) begin
            r_o_v   <= r_res_v;
            r_o_st  <= r_res_st;
            r_o_k   <= r_res_k;
            r_o_idx <= r_res_idx;
            r_o_pfx <= r_res_pfx;
            r_o_net <= r_res_net;
            r_olast <= 1'b1;
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {6'd0, r_o_net, r_o_pfx, r_o_idx, r_o_k, r_o_st, r_o_v};

    // checks
    a_hcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HCW'(HOST_SLOTS))
        else $error("host count above store size");

    a_ncnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= NCW'(NET_SLOTS))
        else $error("network count above store size");

    a_cnt_only_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_FIN) |=> ($stable(r_hcnt) && $stable(r_ncnt)))
        else $error("rule count moved outside finish");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_m_tready) |=> (r_ov && $stable(r_o_net) && $stable(r_olast)))
        else $error("stalled result overwritten");

    a_match_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNTW'(ipf_pkg::LOOKUP_LIMIT))
        else $error("too many lookup-all matches");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ipv4 host and prefix filter: a directed table of
// rule inserts and lookups, then randomized traffic under four idle patterns,
// every result compared with a typed row's value or an access-list predictor
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS       = 22;
    localparam int RAND_ITEMS = 290;
    localparam int DRAIN_CYC  = 150;
    localparam int WDOG_LIMIT = 6000;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [1:0]  status;
        logic [1:0]  kind;
        logic [5:0]  index;
        logic [5:0]  prefix;
        logic [31:0] net;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [1:0]  rv;
        logic        typed;
        t_res        res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic        i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;   // action, address, prefix_len, rule_verdict
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;   // verdict, insert_status, match_kind, match_index,
                              // match_prefix, match_net
    logic        o_m_tlast;

    ipv4_host_and_prefix_filter u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // predictor copy of the rule stores
    logic [31:0] hosts [ipf_pkg::HOST_SLOTS_DEF];
    logic [1:0]  host_rv [ipf_pkg::HOST_SLOTS_DEF];
    int          host_cnt;
    logic [31:0] nets [ipf_pkg::NET_SLOTS_DEF];
    logic [5:0]  net_len [ipf_pkg::NET_SLOTS_DEF];
    logic [1:0]  net_rv [ipf_pkg::NET_SLOTS_DEF];
    int          net_cnt;
    logic        acl_enable;
    logic        dup_err;

    t_res        pending_q [$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          quiet_cycles;
    t_row        rows [ROWS];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] len_mask(input logic [5:0] len);
        if (len == 6'd0) return 32'h0;
        if (len >= 6'd32) return 32'hFFFF_FFFF;
        return 32'hFFFF_FFFF << (6'd32 - len);
    endfunction

    function automatic t_res mk(input logic [1:0] verdict, input logic [1:0] status,
                                input logic [1:0] kind, input int index,
                                input logic [5:0] prefix, input logic [31:0] net,
                                input logic last);
        t_res r;
        r.verdict = verdict;
        r.status  = status;
        r.kind    = kind;
        r.index   = 6'(index);
        r.prefix  = prefix;
        r.net     = net;
        r.last    = last;
        return r;
    endfunction

    task automatic apply_rule(input logic [31:0] a_in, input logic [5:0] l_in,
                              input logic [1:0] v_in);
        logic [31:0] a;
        logic [5:0]  l;
        logic [1:0]  v;
        logic [1:0]  dup_st;
        a = a_in;
        l = (l_in > 6'd32) ? 6'd32 : l_in;
        v = (v_in > 2'd2) ? ipf_pkg::RV_NEITHER : v_in;
        dup_st = dup_err ? ipf_pkg::ST_DUP_ERR : ipf_pkg::ST_DUP_IGN;
        if (l == 6'd32) begin
            for (int i = 0; i < host_cnt; i++) begin
                if (hosts[i] == a) begin
                    pending_q.push_back(mk(ipf_pkg::V_NOMATCH, dup_st, ipf_pkg::KIND_HOST,
                                           i, ipf_pkg::HOST_LEN, a, 1));
                    return;
                end
            end
            if (host_cnt >= ipf_pkg::HOST_SLOTS_DEF) begin
                pending_q.push_back(mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_FULL,
                                       ipf_pkg::KIND_NONE, 0, 0, 0, 1));
                return;
            end
            hosts[host_cnt]   = a;
            host_rv[host_cnt] = v;
            pending_q.push_back(mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_HOST,
                                   host_cnt, ipf_pkg::HOST_LEN, a, 1));
            host_cnt++;
        end else begin
            a = a & len_mask(l);
            for (int i = 0; i < net_cnt; i++) begin
                if (nets[i] == a && net_len[i] == l) begin
                    pending_q.push_back(mk(ipf_pkg::V_NOMATCH, dup_st, ipf_pkg::KIND_NET,
                                           i, l, a, 1));
                    return;
                end
            end
            if (net_cnt >= ipf_pkg::NET_SLOTS_DEF) begin
                pending_q.push_back(mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_FULL,
                                       ipf_pkg::KIND_NONE, 0, 0, 0, 1));
                return;
            end
            nets[net_cnt]    = a;
            net_len[net_cnt] = l;
            net_rv[net_cnt]  = v;
            pending_q.push_back(mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_NET,
                                   net_cnt, l, a, 1));
            net_cnt++;
        end
    endtask

    task automatic predict_acl(input logic [1:0] act, input logic [31:0] a,
                               input logic [5:0] l, input logic [1:0] v);
        int  n;
        logic live;
        n = 0;
        live = acl_enable && (host_cnt + net_cnt) != 0;
        case (act)
            ipf_pkg::ACT_INSERT: begin
                apply_rule(a, l, v);
            end
            ipf_pkg::ACT_FIRST: begin
                if (live) begin
                    for (int i = 0; i < host_cnt; i++) begin
                        if (hosts[i] == a) begin
                            pending_q.push_back(mk(host_rv[i] + 2'd1, ipf_pkg::ST_ADDED,
                                                   ipf_pkg::KIND_HOST, i, ipf_pkg::HOST_LEN,
                                                   hosts[i], 1));
                            return;
                        end
                    end
                    for (int i = 0; i < net_cnt; i++) begin
                        if ((a & len_mask(net_len[i])) == nets[i]) begin
                            pending_q.push_back(mk(net_rv[i] + 2'd1, ipf_pkg::ST_ADDED,
                                                   ipf_pkg::KIND_NET, i, net_len[i],
                                                   nets[i], 1));
                            return;
                        end
                    end
                end
                pending_q.push_back(mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED,
                                       ipf_pkg::KIND_NONE, 0, 0, 0, 1));
            end
            ipf_pkg::ACT_ALL: begin
                if (live) begin
                    for (int i = 0; i < host_cnt && n < ipf_pkg::LOOKUP_LIMIT; i++) begin
                        if (hosts[i] == a && host_rv[i] == ipf_pkg::RV_POSITIVE) begin
                            pending_q.push_back(mk(ipf_pkg::V_POSITIVE, ipf_pkg::ST_ADDED,
                                                   ipf_pkg::KIND_HOST, i, ipf_pkg::HOST_LEN,
                                                   hosts[i], 0));
                            n++;
                        end
                    end
                    for (int i = 0; i < net_cnt && n < ipf_pkg::LOOKUP_LIMIT; i++) begin
                        if (net_rv[i] == ipf_pkg::RV_POSITIVE &&
                            (a & len_mask(net_len[i])) == nets[i]) begin
                            pending_q.push_back(mk(ipf_pkg::V_POSITIVE, ipf_pkg::ST_ADDED,
                                                   ipf_pkg::KIND_NET, i, net_len[i],
                                                   nets[i], 0));
                            n++;
                        end
                    end
                end
                if (n == 0) begin
                    pending_q.push_back(mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED,
                                           ipf_pkg::KIND_NONE, 0, 0, 0, 1));
                end else begin
                    pending_q[pending_q.size()-1].last = 1'b1;
                end
            end
            default: ;  // unused action code gives nothing
        endcase
    endtask

    // one transfer on the slave side; prediction happens on acceptance
    task automatic send_item(input logic [1:0] act, input logic [31:0] a,
                             input logic [5:0] l, input logic [1:0] v,
                             input logic typed, input t_res res);
        logic done;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < send_idle_pct) begin
                i_s_tvalid <= 1'b0;
            end else begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {6'd0, v, l, a, act};
                do @(posedge i_clk); while (!o_s_tready);
                predict_acl(act, a, l, v);
                if (typed) begin
                    void'(pending_q.pop_back());
                    pending_q.push_back(res);
                end
                done = 1'b1;
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        // quiet gap before any config write
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == ipf_pkg::CFG_ENABLE) acl_enable = data;
        else dup_err = data;
    endtask

    task automatic send_random();
        logic [1:0]  act;
        logic [31:0] a;
        logic [5:0]  l;
        int          r;
        r = $urandom_range(0, 99);
        act = (r < 45) ? ipf_pkg::ACT_INSERT : (r < 72) ? ipf_pkg::ACT_FIRST :
              (r < 95) ? ipf_pkg::ACT_ALL : ipf_pkg::ACT_NONE;
        // mostly a small 10/8 pool so rules overlap and lookups hit
        if ($urandom_range(0, 3) == 0) a = $urandom;
        else a = {8'h0A, 8'h00, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 127))};
        r = $urandom_range(0, 9);
        l = (r < 5) ? 6'd32 : (r < 9) ? 6'($urandom_range(0, 31)) : 6'($urandom_range(33, 63));
        send_item(act, a, l, 2'($urandom_range(0, 3)), 1'b0, '0);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = mk(o_m_tdata[1:0], o_m_tdata[3:2], o_m_tdata[5:4], o_m_tdata[11:6],
                     o_m_tdata[17:12], o_m_tdata[49:18], o_m_tlast);
            if (pending_q.size() == 0) begin
                $error("unexpected result transfer %h", o_m_tdata);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (got.verdict != want.verdict) begin
                    $error("verdict exp %0d got %0d", want.verdict, got.verdict); errors++;
                end
                if (got.status != want.status) begin
                    $error("insert_status exp %0d got %0d", want.status, got.status); errors++;
                end
                if (got.kind != want.kind) begin
                    $error("match_kind exp %0d got %0d", want.kind, got.kind); errors++;
                end
                if (got.index != want.index) begin
                    $error("match_index exp %0d got %0d", want.index, got.index); errors++;
                end
                if (got.prefix != want.prefix) begin
                    $error("match_prefix exp %0d got %0d", want.prefix, got.prefix); errors++;
                end
                if (got.net != want.net) begin
                    $error("match_net exp %h got %h", want.net, got.net); errors++;
                end
                if (got.last != want.last) begin
                    $error("last exp %0d got %0d", want.last, got.last); errors++;
                end
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = 1'b0;
        i_cfg_data     = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_m_tready     = 1'b0;
        host_cnt       = 0;
        net_cnt        = 0;
        acl_enable     = 1'b0;
        dup_err        = 1'b1;
        errors         = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // first block runs with the reset configuration (filter disabled)
        rows[0]  = '{ipf_pkg::ACT_FIRST,  32'h0A00_0001, 6'd0,  2'd0, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_NONE,
                        0, 0, 0, 1)};
        rows[1]  = '{ipf_pkg::ACT_ALL,    32'hFFFF_FFFF, 6'd0,  2'd0, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_NONE,
                        0, 0, 0, 1)};
        rows[2]  = '{ipf_pkg::ACT_INSERT, 32'h0A00_0001, 6'd32, 2'd0, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_HOST,
                        0, 32, 32'h0A00_0001, 1)};
        rows[3]  = '{ipf_pkg::ACT_INSERT, 32'h0A00_0001, 6'd32, 2'd1, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_DUP_ERR, ipf_pkg::KIND_HOST,
                        0, 32, 32'h0A00_0001, 1)};
        rows[4]  = '{ipf_pkg::ACT_INSERT, 32'hFFFF_FFFF, 6'd0,  2'd1, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_NET,
                        0, 0, 0, 1)};
        rows[5]  = '{ipf_pkg::ACT_INSERT, 32'hFFFF_FFFF, 6'd63, 2'd3, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_HOST,
                        1, 32, 32'hFFFF_FFFF, 1)};
        rows[6]  = '{ipf_pkg::ACT_INSERT, 32'h0000_0000, 6'd33, 2'd2, 1'b0, '0};
        rows[7]  = '{ipf_pkg::ACT_NONE,   32'hDEAD_BEEF, 6'd5,  2'd3, 1'b0, '0};
        rows[8]  = '{ipf_pkg::ACT_FIRST,  32'hFFFF_FFFF, 6'd0,  2'd0, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_NONE,
                        0, 0, 0, 1)};
        rows[9]  = '{ipf_pkg::ACT_INSERT, 32'h0A01_0203, 6'd8,  2'd0, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_ADDED, ipf_pkg::KIND_NET,
                        1, 8, 32'h0A00_0000, 1)};
        rows[10] = '{ipf_pkg::ACT_INSERT, 32'h0A00_0000, 6'd8,  2'd2, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_DUP_ERR, ipf_pkg::KIND_NET,
                        1, 8, 32'h0A00_0000, 1)};
        // second block after enabling the filter, duplicates ignored
        rows[11] = '{ipf_pkg::ACT_FIRST,  32'h0A00_0001, 6'd0,  2'd0, 1'b0, '0};
        rows[12] = '{ipf_pkg::ACT_ALL,    32'h0A00_0001, 6'd0,  2'd0, 1'b0, '0};
        rows[13] = '{ipf_pkg::ACT_INSERT, 32'h0A00_0001, 6'd32, 2'd0, 1'b1,
                     mk(ipf_pkg::V_NOMATCH, ipf_pkg::ST_DUP_IGN, ipf_pkg::KIND_HOST,
                        0, 32, 32'h0A00_0001, 1)};
        rows[14] = '{ipf_pkg::ACT_FIRST,  32'hC0A8_0101, 6'd0,  2'd0, 1'b0, '0};
        rows[15] = '{ipf_pkg::ACT_INSERT, 32'hAAAA_AAAB, 6'd31, 2'd0, 1'b0, '0};
        rows[16] = '{ipf_pkg::ACT_INSERT, 32'h8000_0000, 6'd1,  2'd0, 1'b0, '0};
        rows[17] = '{ipf_pkg::ACT_ALL,    32'hFFFF_FFFF, 6'd63, 2'd3, 1'b0, '0};
        rows[18] = '{ipf_pkg::ACT_FIRST,  32'h0000_0000, 6'd63, 2'd3, 1'b0, '0};
        rows[19] = '{ipf_pkg::ACT_ALL,    32'hAAAA_AAAA, 6'd0,  2'd0, 1'b0, '0};
        rows[20] = '{ipf_pkg::ACT_INSERT, 32'h5555_5555, 6'd16, 2'd1, 1'b0, '0};
        rows[21] = '{ipf_pkg::ACT_ALL,    32'h0A00_0001, 6'd0,  2'd0, 1'b0, '0};

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < ROWS; r++) begin
            if (r == 11) begin
                wait_idle();
                write_cfg(ipf_pkg::CFG_ENABLE, 1'b1);
                write_cfg(ipf_pkg::CFG_DUPERR, 1'b0);
            end
            send_item(rows[r].act, rows[r].addr, rows[r].len, rows[r].rv,
                      rows[r].typed, rows[r].res);
        end

        for (int ph = 0; ph < 4; ph++) begin
            // sender holds off here until every result has come back
            wait_idle();
            write_cfg(ipf_pkg::CFG_DUPERR, ph[0]);
            write_cfg(ipf_pkg::CFG_ENABLE, ph != 2);
            send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 9 : 0;
            recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 9 : 0;
            for (int k = 0; k < RAND_ITEMS / 4; k++) begin
                send_random();
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
